### rtl/epoch_to_calendar_unit_macros.svh
// Assertion macros shared by the epoch-to-calendar RTL.
`ifndef EPOCH_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_TO_CALENDAR_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ECU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("epoch_to_calendar_unit: same-cycle check failed");

// Next-cycle implication, off during reset.
`define ECU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("epoch_to_calendar_unit: next-cycle check failed");

`endif

### rtl/ecu_pkg.sv
// Types, constants and calendar helpers for the epoch-to-calendar unit.
package ecu_pkg;

   localparam int RemWidth  = 31;
   localparam int SpanWidth = 22;

   localparam logic [10:0]          EpochYear   = 11'd1970;
   localparam logic [10:0]          YearMax     = 11'd2038;
   localparam logic [SpanWidth-1:0] SecsPerDay  = 22'd86400;
   localparam logic [SpanWidth-1:0] SecsPerHour = 22'd3600;
   localparam logic [SpanWidth-1:0] SecsPerMin  = 22'd60;
   localparam logic [9:0]           MillisMax   = 10'd999;
   localparam logic [3:0]           MonthLast   = 4'd11;

   // Position of the epoch year within the 4, 100 and 400 year cycles
   localparam logic [1:0] Cycle4Init   = 2'd2;
   localparam logic [6:0] Cycle100Init = 7'd70;
   localparam logic [8:0] Cycle400Init = 9'd370;
   localparam logic [6:0] Cycle100Last = 7'd99;
   localparam logic [8:0] Cycle400Last = 9'd399;

   typedef struct packed {
      logic [30:0] unix_seconds;
      logic [9:0]  millis_in;
   } req_payload_type;

   typedef struct packed {
      logic [10:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic [9:0]  millis_out;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MONTH,
      ST_DAY,
      ST_HOUR,
      ST_MINUTE,
      ST_FINISH
   } ctl_state_type;

   typedef enum logic [1:0] {
      UNIT_MONTH,
      UNIT_DAY,
      UNIT_HOUR,
      UNIT_MINUTE
   } unit_type;

   typedef struct packed {
      logic     load;
      logic     step;
      unit_type unit;
      logic     publish;
   } dp_cmd_type;

   typedef struct packed {
      logic fits;
   } dp_status_type;

   // Month length in seconds; month is 0-based
   function automatic logic [SpanWidth-1:0] month_span(input logic [3:0] month,
                                                       input logic leap);
      logic [SpanWidth-1:0] span;
      case (month) inside
         4'd1:                   span = leap ? 22'd2505600 : 22'd2419200;
         4'd3, 4'd5, 4'd8, 4'd10: span = 22'd2592000;
         default:                span = 22'd2678400;
      endcase
      return span;
   endfunction

endpackage

### rtl/ecu_ctl.sv
// Controller state machine sequencing the month walk and time-of-day split.
`include "epoch_to_calendar_unit_macros.svh"

module ecu_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ecu_pkg::dp_cmd_type   cmd,
   input  ecu_pkg::dp_status_type status
);
   import ecu_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MONTH;
         ST_MONTH:  if (!status.fits) state_in = ST_DAY;
         ST_DAY:    if (!status.fits) state_in = ST_HOUR;
         ST_HOUR:   if (!status.fits) state_in = ST_MINUTE;
         ST_MINUTE: if (!status.fits) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.unit  = UNIT_MONTH;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MONTH: begin
            cmd.step = 1'b1;
            cmd.unit = UNIT_MONTH;
         end
         ST_DAY: begin
            cmd.step = 1'b1;
            cmd.unit = UNIT_DAY;
         end
         ST_HOUR: begin
            cmd.step = 1'b1;
            cmd.unit = UNIT_HOUR;
         end
         ST_MINUTE: begin
            cmd.step = 1'b1;
            cmd.unit = UNIT_MINUTE;
         end
         ST_FINISH: cmd.publish = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ECU_ASSERT_NOW(a_publish_free, clock, reset, cmd.publish, !rsp_valid_ff || rsp_ready)
   `ECU_ASSERT_NEXT(a_load_walks, clock, reset, req_valid && req_ready, state_ff == ST_MONTH)
   `ECU_ASSERT_NEXT(a_publish_shows, clock, reset, cmd.publish, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

### rtl/ecu_dp.sv
// Datapath: remainder, calendar counters and result register.
`include "epoch_to_calendar_unit_macros.svh"

module ecu_dp (
   input  logic                    clock,
   input  ecu_pkg::req_payload_type req_payload,
   input  ecu_pkg::dp_cmd_type     cmd,
   output ecu_pkg::dp_status_type  status,
   output ecu_pkg::rsp_payload_type rsp_payload
);
   import ecu_pkg::*;

   logic [RemWidth-1:0]  rem_ff;
   logic [10:0]          year_ff;
   logic [3:0]           month_ff;
   logic [4:0]           day_ff;
   logic [4:0]           hour_ff;
   logic [5:0]           minute_ff;
   logic [9:0]           millis_ff;
   logic [1:0]           cyc4_ff;
   logic [6:0]           cyc100_ff;
   logic [8:0]           cyc400_ff;
   rsp_payload_type      rsp_ff;

   logic                 leap;
   logic [SpanWidth-1:0] divisor;
   logic [RemWidth-1:0]  divisor_ext;
   logic                 fits;

   assign leap = (cyc4_ff == 2'd0) && ((cyc100_ff != 7'd0) || (cyc400_ff == 9'd0));

   always_comb begin
      case (cmd.unit)
         UNIT_MONTH:  divisor = month_span(month_ff, leap);
         UNIT_DAY:    divisor = SecsPerDay;
         UNIT_HOUR:   divisor = SecsPerHour;
         UNIT_MINUTE: divisor = SecsPerMin;
         default:     divisor = SecsPerMin;
      endcase
   end

   assign divisor_ext = {{(RemWidth-SpanWidth){1'b0}}, divisor};
   assign fits        = rem_ff >= divisor_ext;
   assign status.fits = fits;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff    <= req_payload.unix_seconds;
         millis_ff <= (req_payload.millis_in > MillisMax) ? 10'd0 : req_payload.millis_in;
         year_ff   <= EpochYear;
         month_ff  <= 4'd0;
         day_ff    <= 5'd0;
         hour_ff   <= 5'd0;
         minute_ff <= 6'd0;
         cyc4_ff   <= Cycle4Init;
         cyc100_ff <= Cycle100Init;
         cyc400_ff <= Cycle400Init;
      end else if (cmd.step && fits) begin
         rem_ff <= rem_ff - divisor_ext;
         case (cmd.unit)
            UNIT_MONTH: begin
               if (month_ff == MonthLast) begin
                  month_ff  <= 4'd0;
                  year_ff   <= year_ff + 11'd1;
                  cyc4_ff   <= cyc4_ff + 2'd1;
                  cyc100_ff <= (cyc100_ff == Cycle100Last) ? 7'd0 : cyc100_ff + 7'd1;
                  cyc400_ff <= (cyc400_ff == Cycle400Last) ? 9'd0 : cyc400_ff + 9'd1;
               end else begin
                  month_ff <= month_ff + 4'd1;
               end
            end
            UNIT_DAY:    day_ff    <= day_ff + 5'd1;
            UNIT_HOUR:   hour_ff   <= hour_ff + 5'd1;
            UNIT_MINUTE: minute_ff <= minute_ff + 6'd1;
            default:     minute_ff <= minute_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_ff.year_out   <= year_ff;
         rsp_ff.month_out  <= month_ff + 4'd1;
         rsp_ff.day_out    <= day_ff + 5'd1;
         rsp_ff.hour_out   <= hour_ff;
         rsp_ff.minute_out <= minute_ff;
         rsp_ff.second_out <= rem_ff[5:0];
         rsp_ff.millis_out <= millis_ff;
      end
   end

   assign rsp_payload = rsp_ff;

   `ECU_ASSERT_NOW(a_month_range, clock, 1'b0, cmd.step, month_ff <= MonthLast)
   `ECU_ASSERT_NOW(a_year_range, clock, 1'b0, cmd.step, year_ff <= YearMax)
   `ECU_ASSERT_NEXT(a_hour_count, clock, 1'b0, cmd.step && fits && cmd.unit == UNIT_HOUR, hour_ff == $past(hour_ff) + 5'd1)

endmodule

### rtl/epoch_to_calendar_unit.sv
// Top level of the epoch-to-calendar unit: controller plus datapath.
//
//   channel   direction  handshake              beat
//   req_      in         req_valid / req_ready  unix_seconds, millis_in
//   rsp_      out        rsp_valid / rsp_ready  year .. second, millis_out
//
// One beat in, one beat out; one item is in work at a time.
// The month walk, one month per cycle through the shared subtractor, dominates the time
// per item, ahead of the day, hour and minute steps.
// The result register frees the walk: a new beat is taken while a result waits.
// Reset (synchronous) returns the controller to idle and drops any pending result.
module epoch_to_calendar_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ecu_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ecu_pkg::rsp_payload_type  rsp_payload
);
   import ecu_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   ecu_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   ecu_dp u_dp (
      .clock       (clock),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

### verif/tb_epoch_to_calendar_unit.sv
// Testbench for epoch_to_calendar_unit: directed and random beats against a calendar predictor.
`timescale 1ns / 1ps

module tb_epoch_to_calendar_unit;
   import ecu_pkg::*;

   localparam int unsigned CycleLimit = 4_000_000;
   localparam int unsigned DaySecs    = 86400;
   localparam int unsigned LastMonth  = 816;    // January 2038, counted from January 1970

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   rsp_payload_type pending_dates[$];
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     stall_pct = 0;

   epoch_to_calendar_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned days_in(input int unsigned month, input int unsigned yr);
      bit leap;
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      case (month)
         1:             return leap ? 29 : 28;
         3, 5, 8, 10:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic rsp_payload_type calendar_of(input req_payload_type beat);
      rsp_payload_type date;
      int unsigned     rest;
      int unsigned     yr;
      int unsigned     month;
      int unsigned     span;
      rest  = beat.unix_seconds;
      yr    = EpochYear;
      month = 0;
      span  = days_in(month, yr) * DaySecs;
      while (rest >= span) begin
         rest -= span;
         if (month == 11) begin
            month = 0;
            yr++;
         end else begin
            month++;
         end
         span = days_in(month, yr) * DaySecs;
      end
      date.year_out   = 11'(yr);
      date.month_out  = 4'(month + 1);
      date.day_out    = 5'(rest / DaySecs + 1);
      rest            = rest % DaySecs;
      date.hour_out   = 5'(rest / 3600);
      rest            = rest % 3600;
      date.minute_out = 6'(rest / 60);
      date.second_out = 6'(rest % 60);
      date.millis_out = (beat.millis_in > MillisMax) ? 10'd0 : beat.millis_in;
      return date;
   endfunction

   function automatic int unsigned month_start(input int unsigned months);
      int unsigned secs;
      int unsigned yr;
      int unsigned month;
      secs  = 0;
      yr    = EpochYear;
      month = 0;
      repeat (months) begin
         secs += days_in(month, yr) * DaySecs;
         if (month == 11) begin
            month = 0;
            yr++;
         end else begin
            month++;
         end
      end
      return secs;
   endfunction

   function automatic req_payload_type random_epoch_beat();
      req_payload_type beat;
      int unsigned     base;
      case ($urandom_range(9))
         0, 1, 2, 3: beat.unix_seconds = 31'($urandom);
         4:          beat.unix_seconds = 31'($urandom_range(3 * DaySecs));
         default: begin
            base = month_start($urandom_range(1, LastMonth));
            case ($urandom_range(4))
               0:       beat.unix_seconds = 31'(base - 1);
               1:       beat.unix_seconds = 31'(base);
               2:       beat.unix_seconds = 31'(base + 1);
               3:       beat.unix_seconds = 31'(base + $urandom_range(DaySecs - 1));
               default: beat.unix_seconds = 31'(base - 1 - $urandom_range(DaySecs - 1));
            endcase
         end
      endcase
      if ($urandom_range(3) == 0) begin
         beat.millis_in = 10'($urandom);
      end else begin
         beat.millis_in = 10'($urandom_range(MillisMax));
      end
      return beat;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            $error("rsp beat with nothing outstanding");
            mismatch_count++;
         end else begin
            want = pending_dates.pop_front();
            check_field("year_out", want.year_out, rsp_payload.year_out);
            check_field("month_out", want.month_out, rsp_payload.month_out);
            check_field("day_out", want.day_out, rsp_payload.day_out);
            check_field("hour_out", want.hour_out, rsp_payload.hour_out);
            check_field("minute_out", want.minute_out, rsp_payload.minute_out);
            check_field("second_out", want.second_out, rsp_payload.second_out);
            check_field("millis_out", want.millis_out, rsp_payload.millis_out);
         end
      end
      if (!reset && req_valid && req_ready) begin
         pending_dates.push_back(calendar_of(req_payload));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_beat(input req_payload_type beat);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_epoch(input int unsigned secs, input int unsigned millis);
      req_payload_type beat;
      beat.unix_seconds = 31'(secs);
      beat.millis_in    = 10'(millis);
      send_beat(beat);
   endtask

   task automatic drain_dates();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_dates.size() != 0);
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) send_beat(random_epoch_beat());
   endtask

   task automatic test_directed();
      send_epoch(0, 0);
      send_epoch(2147483647, 1023);
      send_epoch(59, 999);
      send_epoch(60, 1000);
      send_epoch(3599, 1);
      send_epoch(3600, 512);
      send_epoch(86399, 341);
      send_epoch(86400, 682);
      send_epoch(2678399, 998);
      send_epoch(2678400, 1001);
      send_epoch(5097599, 0);
      send_epoch(5097600, 999);
      send_epoch(68169599, 7);
      send_epoch(68169600, 1022);
      send_epoch(68255999, 500);
      send_epoch(68256000, 250);
      send_epoch(946684799, 999);
      send_epoch(946684800, 1000);
      send_epoch(951782400, 100);
      send_epoch(951868799, 10);
      send_epoch(951868800, 1023);
      send_epoch(1230767999, 123);
      send_epoch(2145916799, 876);
      send_epoch(2145916800, 0);
      drain_dates();
   endtask

   task automatic test_random_flat();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_random(130);
   endtask

   task automatic test_sender_idle();
      send_idle_pct = 70;
      stall_pct     = 0;
      send_random(150);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct = 0;
      stall_pct     = 70;
      send_random(150);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 28;
      stall_pct     = 28;
      send_random(150);
   endtask

   task automatic test_drain_pause();
      send_idle_pct = 0;
      stall_pct     = 28;
      send_random(70);
      drain_dates();
      send_random(70);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_flat();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_drain_pause();
      drain_dates();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/ecu_pkg.sv
rtl/ecu_ctl.sv
rtl/ecu_dp.sv
rtl/epoch_to_calendar_unit.sv
verif/tb_epoch_to_calendar_unit.sv
